FILE: sv/ultrasonic_range_alarm_macros.svh
// Assertion macros shared by the ultrasonic range alarm RTL.
`ifndef ULTRASONIC_RANGE_ALARM_MACROS_SVH
`define ULTRASONIC_RANGE_ALARM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define URA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ultrasonic_range_alarm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define URA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ultrasonic_range_alarm: next-cycle check failed");

`endif

FILE: sv/ura_pkg.sv
// Types and constants shared by the ultrasonic range alarm modules.
`timescale 1ns / 1ps

package ura_pkg;

  localparam int unsigned TRIG_W  = 10;
  localparam int unsigned TICK_W  = 24;
  localparam int unsigned RANGE_W = 14;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;

  // 0.0343 cm/us halved, in mm per us, as unsigned 0.16 fixed point.
  localparam logic [13:0] MM_SCALE  = 14'd11239;
  localparam logic [RANGE_W-1:0] RANGE_MAX = 14'd16383;

  localparam logic [TRIG_W-1:0]  TRIGGER_US_RST = 10'd10;
  localparam logic [TICK_W-1:0]  SETTLE_US_RST  = 24'd100000;
  localparam logic [TICK_W-1:0]  GAP_US_RST     = 24'd5000000;
  localparam logic [RANGE_W-1:0] NEAR_MM_RST    = 14'd100;
  localparam logic [RANGE_W-1:0] FAR_MM_RST     = 14'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_US    = 3'd0,
    CFG_SETTLE_US     = 3'd1,
    CFG_REPEAT_GAP_US = 3'd2,
    CFG_NEAR_MM       = 3'd3,
    CFG_FAR_MM        = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_TRIGGER = 3'd0,
    PH_WAIT    = 3'd1,
    PH_MEASURE = 3'd2,
    PH_SETTLE  = 3'd3,
    PH_GAP     = 3'd4
  } phase_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_us;
    logic [TICK_W-1:0]  settle_us;
    logic [TICK_W-1:0]  repeat_gap_us;
    logic [RANGE_W-1:0] near_mm;
    logic [RANGE_W-1:0] far_mm;
  } cfg_t;

  typedef struct packed {
    logic               trigger_out;
    logic               range_valid;
    logic [RANGE_W-1:0] range_mm;
    logic               lights_on;
    logic               buzzer_on;
  } result_t;

endpackage

FILE: sv/ultrasonic_range_alarm.sv
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per clock; the only stall is a held result that
// the output side has not taken, set by the single result register.
// Reset (synchronous, active low): trigger phase with zero counts, range and
// alarms cleared, configuration back to its defaults, no result pending.
`timescale 1ns / 1ps
`include "ultrasonic_range_alarm_macros.svh"

module ultrasonic_range_alarm #(
  parameter int unsigned ECHO_COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_echo_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_trigger_out,
  output logic                           out_range_valid,
  output logic [ura_pkg::RANGE_W-1:0]    out_range_mm,
  output logic                           out_lights_on,
  output logic                           out_buzzer_on,
  input  logic                           cfg_we,
  input  logic [ura_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ura_pkg::CFG_W-1:0]      cfg_data
);

  ura_pkg::cfg_t                cfg;
  ura_pkg::result_t             res;
  ura_pkg::result_t             out_res;
  logic                         accept;
  logic [ECHO_COUNT_BITS-1:0]   echo_width;
  logic [ura_pkg::RANGE_W-1:0]  range_scaled;

  ura_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ura_scale #(.ECHO_COUNT_BITS(ECHO_COUNT_BITS)) u_scale (
    .echo_width (echo_width),
    .range_mm   (range_scaled)
  );

  ura_ctrl #(.ECHO_COUNT_BITS(ECHO_COUNT_BITS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .echo         (in_echo_level),
    .cfg          (cfg),
    .range_scaled (range_scaled),
    .echo_width   (echo_width),
    .res          (res)
  );

  ura_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .accept    (accept),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_trigger_out = out_res.trigger_out;
  assign out_range_valid = out_res.range_valid;
  assign out_range_mm    = out_res.range_mm;
  assign out_lights_on   = out_res.lights_on;
  assign out_buzzer_on   = out_res.buzzer_on;

  // A held result is never overwritten by a new request.
  `URA_ASSERT_SAME(a_no_overwrite, clk, rst_n, out_valid && !out_ready, !in_ready)
  // Every accepted request produces a result in the next cycle.
  `URA_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)
  // The buzzer only sounds together with the lights.
  `URA_ASSERT_SAME(a_buzzer_lights, clk, rst_n, out_valid && out_buzzer_on, out_lights_on)

endmodule

FILE: sv/ura_cfg_regs.sv
// Configuration register bank for the ultrasonic range alarm.
`timescale 1ns / 1ps

module ura_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ura_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ura_pkg::CFG_W-1:0]        cfg_data,
  output ura_pkg::cfg_t                    cfg
);

  ura_pkg::cfg_t cfg_r;
  ura_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ura_pkg::CFG_TRIGGER_US:    cfg_nxt.trigger_us    = cfg_data[ura_pkg::TRIG_W-1:0];
        ura_pkg::CFG_SETTLE_US:     cfg_nxt.settle_us     = cfg_data[ura_pkg::TICK_W-1:0];
        ura_pkg::CFG_REPEAT_GAP_US: cfg_nxt.repeat_gap_us = cfg_data[ura_pkg::TICK_W-1:0];
        ura_pkg::CFG_NEAR_MM:       cfg_nxt.near_mm       = cfg_data[ura_pkg::RANGE_W-1:0];
        ura_pkg::CFG_FAR_MM:        cfg_nxt.far_mm        = cfg_data[ura_pkg::RANGE_W-1:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_us    <= ura_pkg::TRIGGER_US_RST;
      cfg_r.settle_us     <= ura_pkg::SETTLE_US_RST;
      cfg_r.repeat_gap_us <= ura_pkg::GAP_US_RST;
      cfg_r.near_mm       <= ura_pkg::NEAR_MM_RST;
      cfg_r.far_mm        <= ura_pkg::FAR_MM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/ura_scale.sv
// Echo width to millimetre conversion with saturation.
`timescale 1ns / 1ps

module ura_scale #(
  parameter int unsigned ECHO_COUNT_BITS = 16
) (
  input  logic [ECHO_COUNT_BITS-1:0]      echo_width,
  output logic [ura_pkg::RANGE_W-1:0]     range_mm
);

  localparam int unsigned PROD_W = ECHO_COUNT_BITS + 14;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] mm_full;

  assign prod    = PROD_W'(echo_width) * PROD_W'(ura_pkg::MM_SCALE);
  assign mm_full = prod >> 16;

  always_comb begin
    if (mm_full > PROD_W'(ura_pkg::RANGE_MAX)) begin
      range_mm = ura_pkg::RANGE_MAX;
    end else begin
      range_mm = mm_full[ura_pkg::RANGE_W-1:0];
    end
  end

endmodule

FILE: sv/ura_ctrl.sv
// Measurement sequencer: trigger, echo timing, settle and gap phases, alarms.
`timescale 1ns / 1ps

module ura_ctrl #(
  parameter int unsigned ECHO_COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          echo,
  input  ura_pkg::cfg_t                 cfg,
  input  logic [ura_pkg::RANGE_W-1:0]   range_scaled,
  output logic [ECHO_COUNT_BITS-1:0]    echo_width,
  output ura_pkg::result_t              res
);

  localparam logic [ECHO_COUNT_BITS-1:0] WIDTH_MAX = '1;
  localparam int unsigned TT_W = ura_pkg::TICK_W + 1;

  ura_pkg::phase_t                  phase_r, phase_nxt;
  logic [ura_pkg::TICK_W-1:0]       ticks_r, ticks_nxt;
  logic [ECHO_COUNT_BITS-1:0]       width_r, width_nxt;
  logic [ura_pkg::RANGE_W-1:0]      range_r, range_nxt;
  logic                             lights_r, lights_nxt;
  logic                             buzzer_r, buzzer_nxt;
  logic [TT_W-1:0]                  trig_ticks;

  // Next state.
  always_comb begin
    phase_nxt  = phase_r;
    ticks_nxt  = ticks_r;
    width_nxt  = width_r;
    range_nxt  = range_r;
    lights_nxt = lights_r;
    buzzer_nxt = buzzer_r;
    // An unused phase code restarts the trigger pulse from zero.
    if (phase_r == ura_pkg::PH_TRIGGER) begin
      trig_ticks = TT_W'(ticks_r) + TT_W'(1);
    end else begin
      trig_ticks = TT_W'(1);
    end
    unique case (phase_r)
      ura_pkg::PH_WAIT: begin
        if (echo) begin
          width_nxt = ECHO_COUNT_BITS'(1);
          phase_nxt = ura_pkg::PH_MEASURE;
        end
      end
      ura_pkg::PH_MEASURE: begin
        if (echo) begin
          if (width_r != WIDTH_MAX) begin
            width_nxt = width_r + ECHO_COUNT_BITS'(1);
          end
        end else begin
          range_nxt = range_scaled;
          phase_nxt = ura_pkg::PH_SETTLE;
          ticks_nxt = '0;
        end
      end
      ura_pkg::PH_SETTLE: begin
        if (ticks_r >= cfg.settle_us) begin
          lights_nxt = (range_r < cfg.far_mm);
          buzzer_nxt = (range_r < cfg.far_mm) && (range_r < cfg.near_mm);
          phase_nxt  = ura_pkg::PH_GAP;
          ticks_nxt  = '0;
        end else begin
          ticks_nxt = ticks_r + ura_pkg::TICK_W'(1);
        end
      end
      ura_pkg::PH_GAP: begin
        if (ticks_r >= cfg.repeat_gap_us) begin
          phase_nxt = ura_pkg::PH_TRIGGER;
          ticks_nxt = '0;
        end else begin
          ticks_nxt = ticks_r + ura_pkg::TICK_W'(1);
        end
      end
      default: begin
        if (trig_ticks >= TT_W'(cfg.trigger_us)) begin
          phase_nxt = ura_pkg::PH_WAIT;
          ticks_nxt = '0;
        end else begin
          phase_nxt = ura_pkg::PH_TRIGGER;
          ticks_nxt = trig_ticks[ura_pkg::TICK_W-1:0];
        end
      end
    endcase
  end

  // Outputs of the current tick; the alarms and range show their updated values.
  always_comb begin
    res.range_mm  = range_nxt;
    res.lights_on = lights_nxt;
    res.buzzer_on = buzzer_nxt;
    unique case (phase_r)
      ura_pkg::PH_WAIT,
      ura_pkg::PH_SETTLE,
      ura_pkg::PH_GAP: begin
        res.trigger_out = 1'b0;
        res.range_valid = 1'b0;
      end
      ura_pkg::PH_MEASURE: begin
        res.trigger_out = 1'b0;
        res.range_valid = !echo;
      end
      default: begin
        res.trigger_out = 1'b1;
        res.range_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ura_pkg::PH_TRIGGER;
      ticks_r  <= '0;
      width_r  <= '0;
      range_r  <= '0;
      lights_r <= 1'b0;
      buzzer_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      ticks_r  <= ticks_nxt;
      width_r  <= width_nxt;
      range_r  <= range_nxt;
      lights_r <= lights_nxt;
      buzzer_r <= buzzer_nxt;
    end
  end

  assign echo_width = width_r;

endmodule

FILE: sv/ura_out_reg.sv
// Result register between the sequencer and the output channel.
`timescale 1ns / 1ps

module ura_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              accept,
  input  ura_pkg::result_t  res,
  output logic              out_valid,
  input  logic              out_ready,
  output ura_pkg::result_t  out_res
);

  logic             valid_r, valid_nxt;
  ura_pkg::result_t res_r;

  // A new request may enter when no result is held, or when the held result leaves in the same cycle.
  assign in_ready  = rst_n && (!valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign valid_nxt = accept || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: sim/tb_ultrasonic_range_alarm.sv
// Self-checking testbench for the ultrasonic range alarm: drives echo ticks, predicts every result.
`timescale 1ns / 1ps

module tb_ultrasonic_range_alarm;
  import ura_pkg::*;

  localparam int unsigned ECHO_BITS      = 16;
  localparam int unsigned ECHO_WIDTH_MAX = (1 << ECHO_BITS) - 1;
  localparam longint unsigned MM_PER_US_Q16 = 11239;
  localparam int unsigned STALL_LIMIT    = 1000;
  localparam int unsigned MAX_PRINTED    = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam logic [TICK_W-1:0]    TICK_MAX = 24'hFFFFFF;
  localparam logic [RANGE_W-1:0]   MM_MAX   = 14'h3FFF;

  class range_scoreboard;
    logic [TRIG_W-1:0]  trigger_us;
    logic [TICK_W-1:0]  settle_us;
    logic [TICK_W-1:0]  gap_us;
    logic [RANGE_W-1:0] near_mm;
    logic [RANGE_W-1:0] far_mm;
    phase_t             phase;
    int unsigned        phase_ticks;
    int unsigned        echo_width;
    logic [RANGE_W-1:0] last_range;
    logic               lights;
    logic               buzzer;
    result_t            expected_outputs[$];
    int unsigned        mismatches;

    function new();
      trigger_us  = TRIGGER_US_RST;
      settle_us   = SETTLE_US_RST;
      gap_us      = GAP_US_RST;
      near_mm     = NEAR_MM_RST;
      far_mm      = FAR_MM_RST;
      phase       = PH_TRIGGER;
      phase_ticks = 0;
      echo_width  = 0;
      last_range  = '0;
      lights      = 1'b0;
      buzzer      = 1'b0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_TRIGGER_US:    trigger_us = data[TRIG_W-1:0];
        CFG_SETTLE_US:     settle_us  = data[TICK_W-1:0];
        CFG_REPEAT_GAP_US: gap_us     = data[TICK_W-1:0];
        CFG_NEAR_MM:       near_mm    = data[RANGE_W-1:0];
        CFG_FAR_MM:        far_mm     = data[RANGE_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the controller by one accepted tick and queues the output it must show.
    function void note_echo(logic echo);
      result_t         r;
      longint unsigned mm;
      r = '0;
      case (phase)
        PH_WAIT: begin
          if (echo) begin
            echo_width = 1;
            phase = PH_MEASURE;
          end
        end
        PH_MEASURE: begin
          if (echo) begin
            if (echo_width < ECHO_WIDTH_MAX) echo_width++;
          end else begin
            mm = echo_width;
            mm = (mm * MM_PER_US_Q16) >> 16;
            if (mm > MM_MAX) mm = MM_MAX;
            last_range = mm[RANGE_W-1:0];
            r.range_valid = 1'b1;
            phase = PH_SETTLE;
            phase_ticks = 0;
          end
        end
        PH_SETTLE: begin
          if (phase_ticks >= settle_us) begin
            lights = last_range < far_mm;
            // The buzzer only sounds as part of the close-object alarm.
            buzzer = lights && (last_range < near_mm);
            phase = PH_GAP;
            phase_ticks = 0;
          end else begin
            phase_ticks++;
          end
        end
        PH_GAP: begin
          if (phase_ticks >= gap_us) begin
            phase = PH_TRIGGER;
            phase_ticks = 0;
          end else begin
            phase_ticks++;
          end
        end
        default: begin
          if (phase != PH_TRIGGER) begin
            phase = PH_TRIGGER;
            phase_ticks = 0;
          end
          r.trigger_out = 1'b1;
          phase_ticks++;
          // A zero pulse length still gives one trigger tick.
          if (phase_ticks >= trigger_us) begin
            phase = PH_WAIT;
            phase_ticks = 0;
          end
        end
      endcase
      r.range_mm  = last_range;
      r.lights_on = lights;
      r.buzzer_on = buzzer;
      expected_outputs.push_back(r);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic got_trig, logic got_valid, logic [RANGE_W-1:0] got_mm,
                      logic got_lights, logic got_buzzer);
      result_t want;
      if (expected_outputs.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = expected_outputs.pop_front();
        if (got_trig !== want.trigger_out)
          report($sformatf("trigger_out %b, expected %b", got_trig, want.trigger_out));
        if (got_valid !== want.range_valid)
          report($sformatf("range_valid %b, expected %b", got_valid, want.range_valid));
        if (got_mm !== want.range_mm)
          report($sformatf("range_mm %0d, expected %0d", got_mm, want.range_mm));
        if (got_lights !== want.lights_on)
          report($sformatf("lights_on %b, expected %b", got_lights, want.lights_on));
        if (got_buzzer !== want.buzzer_on)
          report($sformatf("buzzer_on %b, expected %b", got_buzzer, want.buzzer_on));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_echo_level;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_trigger_out;
  logic                 out_range_valid;
  logic [RANGE_W-1:0]   out_range_mm;
  logic                 out_lights_on;
  logic                 out_buzzer_on;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bit              in_idle  = 1'b1;
  bit              out_idle = 1'b1;
  int unsigned     requests_sent = 0;
  range_scoreboard sb;

  ultrasonic_range_alarm #(
    .ECHO_COUNT_BITS(ECHO_BITS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_echo_level  (in_echo_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_trigger_out(out_trigger_out),
    .out_range_valid(out_range_valid),
    .out_range_mm   (out_range_mm),
    .out_lights_on  (out_lights_on),
    .out_buzzer_on  (out_buzzer_on),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_echo(logic level);
    int unsigned wait_cycles;
    wait_cycles = in_idle ? $urandom_range(0, 18) : 0;
    @(negedge clk);
    if (wait_cycles != 0) begin
      in_valid <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
    end
    in_echo_level <= level;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_echo(level);
    requests_sent++;
  endtask

  // Holds off new requests until every outstanding result has been taken.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Narrow registers get random upper data bits, which the block must drop.
  task automatic load_config(cfg_t c, bit poke_unused);
    logic [CFG_W-1:0] d;
    drain();
    d = CFG_W'($urandom);
    d[TRIG_W-1:0] = c.trigger_us;
    put_reg(CFG_TRIGGER_US, d);
    put_reg(CFG_SETTLE_US, c.settle_us);
    put_reg(CFG_REPEAT_GAP_US, c.repeat_gap_us);
    d = CFG_W'($urandom);
    d[RANGE_W-1:0] = c.near_mm;
    put_reg(CFG_NEAR_MM, d);
    d = CFG_W'($urandom);
    d[RANGE_W-1:0] = c.far_mm;
    put_reg(CFG_FAR_MM, d);
    if (poke_unused) put_reg(CFG_IDX_UNUSED, CFG_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One full ranging cycle: run to the echo wait, then a pulse of the given width.
  task automatic measure(int unsigned width, bit noisy);
    int unsigned lows;
    while (sb.phase != PH_WAIT) send_echo(noisy && ($urandom_range(0, 1) == 1));
    lows = $urandom_range(0, 4);
    repeat (lows) send_echo(1'b0);
    repeat (width) send_echo(1'b1);
    send_echo(1'b0);
  endtask

  function automatic cfg_t make_cfg(logic [TRIG_W-1:0] trig, logic [TICK_W-1:0] settle,
                                    logic [TICK_W-1:0] gap, logic [RANGE_W-1:0] near,
                                    logic [RANGE_W-1:0] far);
    make_cfg.trigger_us    = trig;
    make_cfg.settle_us     = settle;
    make_cfg.repeat_gap_us = gap;
    make_cfg.near_mm       = near;
    make_cfg.far_mm        = far;
  endfunction

  // Short timings and thresholds of a few millimetres keep many cycles in a short run.
  function automatic cfg_t random_cfg();
    cfg_t c;
    c.trigger_us    = TRIG_W'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6));
    c.settle_us     = TICK_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 40)
                                                          : $urandom_range(0, 8));
    c.repeat_gap_us = TICK_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 40)
                                                          : $urandom_range(0, 8));
    c.near_mm       = RANGE_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 60)
                                                           : $urandom_range(0, 5));
    c.far_mm        = RANGE_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 60)
                                                           : $urandom_range(0, 5));
    return c;
  endfunction

  function automatic int unsigned random_width();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
  endfunction

  initial begin
    int unsigned hold;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = out_idle ? $urandom_range(0, 18) : 0;
      @(negedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_result(out_trigger_out, out_range_valid, out_range_mm, out_lights_on,
                      out_buzzer_on);
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned stop_at;
    int unsigned kind;
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_echo_level = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: echo during the trigger pulse and during settling is ignored.
    repeat (TRIGGER_US_RST) send_echo(1'b1);
    measure(3, 1'b0);
    repeat (2) send_echo(1'b1);

    // Zero pulse length, no settle or gap, both alarms at their top threshold.
    load_config(make_cfg('0, '0, '0, MM_MAX, MM_MAX), 1'b1);
    measure(1, 1'b0);
    measure(6, 1'b0);
    // A longer echo run without idling keeps requests and results back to back.
    in_idle  = 1'b0;
    out_idle = 1'b0;
    measure(40, 1'b0);
    in_idle  = 1'b1;
    out_idle = 1'b1;

    // Near threshold above far threshold.
    load_config(make_cfg(10'd2, 24'd1, 24'd1, 14'd3, 14'd1), 1'b0);
    measure(1, 1'b0);
    measure(6, 1'b0);
    measure(12, 1'b0);

    // Noisy wait under zero thresholds, then parked in the longest gap.
    load_config(make_cfg(10'd7, '0, '0, '0, '0), 1'b0);
    measure(5, 1'b1);
    load_config(make_cfg(10'd7, '0, TICK_MAX, '0, '0), 1'b0);
    repeat (20) send_echo(1'($urandom_range(0, 1)));

    // Shortest trigger, then parked in the longest settle.
    load_config(make_cfg(10'd1, TICK_MAX, '0, MM_MAX, MM_MAX), 1'b1);
    measure(3, 1'b0);
    repeat (20) send_echo(1'($urandom_range(0, 1)));

    for (int p = 0; p < 6; p++) begin
      load_config(random_cfg(), p[0]);
      stop_at = requests_sent + 40;
      while (requests_sent < stop_at) begin
        in_idle  = $urandom_range(0, 3) != 0;
        out_idle = $urandom_range(0, 3) != 0;
        kind     = $urandom_range(0, 9);
        if (kind < 8)
          measure(random_width(), kind == 7);
        else
          repeat ($urandom_range(1, 12)) send_echo(1'($urandom_range(0, 1)));
      end
    end

    drain();
    if (sb.mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
